@@ rtl/rrts_pkg.sv @@
// Package for the round-robin thread scheduler: command, status and run-state codes.
// No dependencies.
`default_nettype none
package rrts_pkg;
  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_SPAWN  = 3'd1,
    MODE_TERM   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_RESUME = 3'd4,
    MODE_SLEEP  = 3'd5,
    MODE_QUERY  = 3'd6,
    MODE_NOP    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_NO_THR   = 2'd2,
    STAT_MAIN_SLP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RS_READY   = 2'd0,
    RS_RUNNING = 2'd1,
    RS_BLOCKED = 2'd2
  } run_state_e;

  localparam logic [31:0] QuantaMax = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

@@ rtl/rrts_sat_inc.sv @@
// Shared saturating 32-bit incrementer / adder with a <= compare, used by the sequencer.
// Depends on rrts_pkg.
`default_nettype none
module rrts_sat_inc
  import rrts_pkg::*;
(
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o,
  output logic             le_o
);
  logic [32:0] sum_w;
  assign sum_w = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o = sum_w[32] ? QuantaMax : sum_w[31:0];
  // a <= b
  assign le_o  = (a_i <= b_i);
endmodule
`default_nettype wire

@@ rtl/round_robin_thread_scheduler.sv @@
// Round-robin thread scheduler: one command in, one result out.
// Queue removal, the free-id search and the wake scan each visit one slot a cycle; the sleep
// deadline, the quanta bump on a switch and the wake compare share one adder/compare.
// A new command is taken only after the result of the last one has been transferred.
// Not ready with a command in flight or a result waiting; the result holds until transferred.
// Reset (async, active low): thread 0 running, queue empty, global count one.
`default_nettype none
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [3:0]  thread_id_i,
  input  wire logic [15:0] sleep_quanta_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_value_o,
  output logic [3:0]       running_thread_o,
  output logic             running_valid_o,
  output logic [31:0]      total_quanta_o
);
  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_THREADS);
  localparam logic [IW-1:0] IdxLast = IW'(MAX_THREADS - 1);
  localparam logic [CW:0]   SlotWrap = (CW+1)'(MAX_THREADS);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_RMV  = 3'd3;
  localparam logic [2:0] S_SW   = 3'd4;
  localparam logic [2:0] S_WAKE = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  logic [MAX_THREADS-1:0] used_q, blk_q, slp_q;
  logic [1:0]             rs_q [MAX_THREADS];
  logic [31:0]            dl_q [MAX_THREADS];
  logic [31:0]            ptq_q [MAX_THREADS];
  logic [IW-1:0]          fifo_q [MAX_THREADS];
  logic [IW-1:0]          head_q;
  logic [CW-1:0]          cnt_q;
  logic [IW-1:0]          cur_q;
  logic                   curv_q;
  logic [31:0]            gq_q;

  // command latch
  logic [2:0]    mode_q;
  logic [IW-1:0] tid_q;
  logic          tid_ok_q;
  logic [15:0]   slpq_q;
  // scan state
  logic [CW-1:0] k_q;
  logic [CW-1:0] kept_q;
  logic [IW-1:0] rm_q;

  // result register
  logic          ov_q;
  logic [1:0]    st_q;
  logic [31:0]   val_q;

  // shared adder/compare
  logic [31:0] alu_a, alu_b, alu_s;
  logic        alu_le;
  rrts_sat_inc u_alu (.a_i(alu_a), .b_i(alu_b), .sum_o(alu_s), .le_o(alu_le));

  logic [IW-1:0] k_idx;
  assign k_idx = k_q[IW-1:0];

  // queue slot at offset o from h; h + o stays below twice the slot count
  function automatic logic [IW-1:0] fidx(input logic [IW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, h} + {1'b0, o};
    if (s >= SlotWrap) s = s - SlotWrap;
    return s[IW-1:0];
  endfunction

  logic accept;
  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign accept = in_valid_i && !in_stall_o;

  // alu operand select
  always_comb begin
    alu_a = 32'd1;
    alu_b = gq_q;
    unique case (state_q)
      S_DEC: begin
        alu_a = {16'd0, slpq_q};
        alu_b = gq_q;
      end
      S_SW: begin
        alu_a = 32'd1;
        alu_b = (cnt_q != '0) ? ptq_q[fifo_q[head_q]] : ptq_q[cur_q];
      end
      S_WAKE: begin
        alu_a = dl_q[k_idx];
        alu_b = gq_q;
      end
      default: ;
    endcase
  end

  // sat inc of global for S_SW second use: do it separately (cheap 32-bit)
  logic [31:0] gq_inc;
  assign gq_inc = (gq_q == QuantaMax) ? gq_q : gq_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= MAX_THREADS'(1);
      blk_q    <= '0;
      slp_q    <= '0;
      for (int i = 0; i < MAX_THREADS; i++) rs_q[i] <= RS_READY;
      rs_q[0]  <= RS_RUNNING;
      ptq_q[0] <= 32'd1;
      head_q   <= '0;
      cnt_q    <= '0;
      cur_q    <= '0;
      curv_q   <= 1'b1;
      gq_q     <= 32'd1;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= mode_i;
            tid_q    <= IW'(thread_id_i);
            tid_ok_q <= (32'(thread_id_i) < 32'(MAX_THREADS));
            slpq_q   <= sleep_quanta_i;
            st_q     <= STAT_OK;
            val_q    <= '0;
            k_q      <= '0;
            kept_q   <= '0;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          state_q <= S_DONE;
          unique case (mode_q) inside
            MODE_TICK: state_q <= S_SW;
            MODE_SPAWN: begin
              st_q    <= STAT_NO_FREE;
              state_q <= S_SRCH;
            end
            MODE_TERM, MODE_BLOCK, MODE_RESUME, MODE_QUERY: begin
              if (!tid_ok_q || !used_q[tid_q]) begin
                st_q <= STAT_NO_THR;
              end else if (mode_q == MODE_QUERY) begin
                val_q <= ptq_q[tid_q];
              end else if (mode_q == MODE_RESUME) begin
                blk_q[tid_q] <= 1'b0;
                if (rs_q[tid_q] == RS_BLOCKED && !slp_q[tid_q]) begin
                  rs_q[tid_q] <= RS_READY;
                  if (cnt_q < CntMax) begin
                    fifo_q[fidx(head_q, cnt_q)] <= tid_q;
                    cnt_q <= cnt_q + 1'b1;
                  end
                end
              end else if (mode_q == MODE_BLOCK) begin
                blk_q[tid_q] <= 1'b1;
                if (rs_q[tid_q] == RS_RUNNING) begin
                  rs_q[tid_q] <= RS_BLOCKED;
                  state_q <= S_SW;
                end else if (rs_q[tid_q] == RS_READY) begin
                  rs_q[tid_q] <= RS_BLOCKED;
                  rm_q    <= tid_q;
                  state_q <= S_RMV;
                end
              end else begin
                used_q[tid_q] <= 1'b0;
                blk_q[tid_q]  <= 1'b0;
                slp_q[tid_q]  <= 1'b0;
                rs_q[tid_q]   <= RS_READY;
                if (rs_q[tid_q] == RS_RUNNING) begin
                  curv_q  <= 1'b0;
                  cur_q   <= '0;
                  state_q <= S_SW;
                end else if (rs_q[tid_q] == RS_READY) begin
                  rm_q    <= tid_q;
                  state_q <= S_RMV;
                end
              end
            end
            MODE_SLEEP: begin
              if (!curv_q) begin
                st_q <= STAT_NO_THR;
              end else if (cur_q == '0) begin
                st_q <= STAT_MAIN_SLP;
              end else begin
                slp_q[cur_q] <= 1'b1;
                dl_q[cur_q]  <= alu_s;
                rs_q[cur_q]  <= RS_BLOCKED;
                state_q      <= S_SW;
              end
            end
            default: ;
          endcase
        end
        S_SRCH: begin
          // one slot a cycle, lowest free id first
          if (!used_q[k_idx]) begin
            used_q[k_idx] <= 1'b1;
            rs_q[k_idx]   <= RS_READY;
            blk_q[k_idx]  <= 1'b0;
            slp_q[k_idx]  <= 1'b0;
            ptq_q[k_idx]  <= '0;
            if (cnt_q < CntMax) begin
              fifo_q[fidx(head_q, cnt_q)] <= k_idx;
              cnt_q <= cnt_q + 1'b1;
            end
            st_q    <= STAT_OK;
            val_q   <= 32'(k_idx);
            state_q <= S_DONE;
          end else if (k_idx == IdxLast) begin
            state_q <= S_DONE;
          end
          k_q <= k_q + 1'b1;
        end
        S_RMV: begin
          // compact queue in place, one entry a cycle
          if (k_q == cnt_q) begin
            cnt_q   <= kept_q;
            state_q <= S_DONE;
          end else begin
            if (fifo_q[fidx(head_q, k_q)] != rm_q) begin
              fifo_q[fidx(head_q, kept_q)] <= fifo_q[fidx(head_q, k_q)];
              kept_q <= kept_q + 1'b1;
            end
            k_q <= k_q + 1'b1;
          end
        end
        S_SW: begin
          // requeue, pop and count in one step; global bump too
          if (curv_q && rs_q[cur_q] == RS_RUNNING) begin
            rs_q[cur_q] <= RS_READY;
            if (cnt_q == '0) begin
              // requeued thread is popped right back
              ptq_q[cur_q] <= alu_s;
              rs_q[cur_q]  <= RS_RUNNING;
            end else begin
              fifo_q[fidx(head_q, cnt_q)] <= cur_q;
              cur_q <= fifo_q[head_q];
              rs_q[fifo_q[head_q]]  <= RS_RUNNING;
              ptq_q[fifo_q[head_q]] <= alu_s;
              head_q <= fidx(head_q, CW'(1));
            end
          end else if (cnt_q != '0) begin
            cur_q  <= fifo_q[head_q];
            curv_q <= 1'b1;
            rs_q[fifo_q[head_q]]  <= RS_RUNNING;
            ptq_q[fifo_q[head_q]] <= alu_s;
            head_q <= fidx(head_q, CW'(1));
            cnt_q  <= cnt_q - 1'b1;
          end else begin
            curv_q <= 1'b0;
            cur_q  <= '0;
          end
          gq_q    <= gq_inc;
          k_q     <= '0;
          state_q <= S_WAKE;
        end
        S_WAKE: begin
          if (used_q[k_idx] && slp_q[k_idx] && alu_le) begin
            slp_q[k_idx] <= 1'b0;
            if (!blk_q[k_idx] && rs_q[k_idx] == RS_BLOCKED) begin
              rs_q[k_idx] <= RS_READY;
              if (cnt_q < CntMax) begin
                fifo_q[fidx(head_q, cnt_q)] <= k_idx;
                cnt_q <= cnt_q + 1'b1;
              end
            end
          end
          k_q <= k_q + 1'b1;
          if (k_idx == IdxLast) state_q <= S_DONE;
        end
        S_DONE: begin
          ov_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign result_value_o   = val_q;
  assign running_thread_o = curv_q ? 4'(cur_q) : 4'd0;
  assign running_valid_o  = curv_q;
  assign total_quanta_o   = gq_q;

  // no command accepted while one is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  // a result only appears after the sequencer finishes
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(state_q) == S_DONE)) else $error("spurious result");
  // queue never exceeds the slot count
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax) else $error("queue overflow");
  // global count never decreases
  a_gq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gq_q >= $past(gq_q)) else $error("global count went down");
endmodule
`default_nettype wire

@@ test/round_robin_thread_scheduler_tb.sv @@
// Testbench for round_robin_thread_scheduler: directed and random scheduler commands,
// each result checked against an in-bench scheduler model. Depends on rrts_pkg and the RTL.
`default_nettype none
module round_robin_thread_scheduler_tb
  import rrts_pkg::*;
;

  localparam int NTHR = 16;
  localparam int IDLE_PCT = 31;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * NTHR + 8;
  localparam int HOLD_CYCLES = 80;
  localparam int EXP_DEPTH = 8;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [3:0]  run_id;
    logic        run_valid;
    logic [31:0] total;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [3:0]  thread_id_i = '0;
  logic [15:0] sleep_quanta_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] result_value_o;
  logic [3:0]  running_thread_o;
  logic        running_valid_o;
  logic [31:0] total_quanta_o;

  round_robin_thread_scheduler dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Scheduler model state.
  bit          slot_used[NTHR];
  run_state_e  slot_state[NTHR];
  bit          held[NTHR];
  bit          sleeping[NTHR];
  logic [31:0] deadline[NTHR];
  logic [31:0] thread_quanta[NTHR];
  logic [3:0]  ready_q[NTHR];
  int          rq_head;
  int          rq_cnt;
  logic [3:0]  cur_id;
  bit          cur_valid;
  logic [31:0] global_quanta;

  // expected results, oldest at exp_rd
  sched_result_t exp_store[EXP_DEPTH];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  errors = 0;
  bit  quiet = 1'b0;     // no idling on either side while set
  bit  hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit  in_fire;
  bit  out_fire;
  int  idle_cycles = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == QuantaMax) ? v : v + 1;
  endfunction

  function automatic void ready_push(int t);
    if (rq_cnt >= NTHR) return;
    ready_q[(rq_head + rq_cnt) % NTHR] = t[3:0];
    rq_cnt++;
  endfunction

  function automatic void ready_drop(int t);
    int kept;
    logic [3:0] e;
    kept = 0;
    for (int k = 0; k < rq_cnt; k++) begin
      e = ready_q[(rq_head + k) % NTHR];
      if (e != t) begin
        ready_q[(rq_head + kept) % NTHR] = e;
        kept++;
      end
    end
    rq_cnt = kept;
  endfunction

  function automatic void switch_thread();
    int t;
    if (cur_valid && slot_state[cur_id] == RS_RUNNING) begin
      slot_state[cur_id] = RS_READY;
      ready_push(cur_id);
    end
    if (rq_cnt > 0) begin
      t = ready_q[rq_head];
      rq_head = (rq_head + 1) % NTHR;
      rq_cnt--;
      cur_id = t[3:0];
      cur_valid = 1'b1;
      slot_state[t] = RS_RUNNING;
      thread_quanta[t] = sat_inc(thread_quanta[t]);
    end else begin
      cur_valid = 1'b0;
      cur_id = '0;
    end
    global_quanta = sat_inc(global_quanta);
    // Wake expired sleepers in ascending id order.
    for (int i = 0; i < NTHR; i++) begin
      if (slot_used[i] && sleeping[i] && deadline[i] <= global_quanta) begin
        sleeping[i] = 1'b0;
        if (!held[i] && slot_state[i] == RS_BLOCKED) begin
          slot_state[i] = RS_READY;
          ready_push(i);
        end
      end
    end
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < NTHR; i++) begin
      slot_used[i] = 1'b0;
      slot_state[i] = RS_READY;
      held[i] = 1'b0;
      sleeping[i] = 1'b0;
      deadline[i] = '0;
      thread_quanta[i] = '0;
      ready_q[i] = '0;
    end
    slot_used[0] = 1'b1;
    slot_state[0] = RS_RUNNING;
    thread_quanta[0] = 1;
    rq_head = 0;
    rq_cnt = 0;
    cur_id = '0;
    cur_valid = 1'b1;
    global_quanta = 1;
  endfunction

  function automatic sched_result_t sched_command(mode_e mode, logic [3:0] tid,
                                                  logic [15:0] nq);
    sched_result_t r;
    bit present;
    logic [32:0] sum;
    r.status = STAT_OK;
    r.value = '0;
    present = slot_used[tid];
    case (mode)
      MODE_TICK: switch_thread();
      MODE_SPAWN: begin
        r.status = STAT_NO_FREE;
        for (int i = 0; i < NTHR; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_state[i] = RS_READY;
            held[i] = 1'b0;
            sleeping[i] = 1'b0;
            thread_quanta[i] = '0;
            ready_push(i);
            r.status = STAT_OK;
            r.value = i;
            break;
          end
        end
      end
      MODE_TERM: begin
        if (!present) r.status = STAT_NO_THR;
        else begin
          slot_used[tid] = 1'b0;
          held[tid] = 1'b0;
          sleeping[tid] = 1'b0;
          if (slot_state[tid] == RS_RUNNING) begin
            slot_state[tid] = RS_READY;
            cur_valid = 1'b0;
            cur_id = '0;
            switch_thread();
          end else if (slot_state[tid] == RS_READY) begin
            ready_drop(tid);
          end
          slot_state[tid] = RS_READY;
        end
      end
      MODE_BLOCK: begin
        if (!present) r.status = STAT_NO_THR;
        else begin
          held[tid] = 1'b1;
          if (slot_state[tid] == RS_RUNNING) begin
            slot_state[tid] = RS_BLOCKED;
            switch_thread();
          end else if (slot_state[tid] == RS_READY) begin
            slot_state[tid] = RS_BLOCKED;
            ready_drop(tid);
          end
        end
      end
      MODE_RESUME: begin
        if (!present) r.status = STAT_NO_THR;
        else begin
          held[tid] = 1'b0;
          if (slot_state[tid] == RS_BLOCKED && !sleeping[tid]) begin
            slot_state[tid] = RS_READY;
            ready_push(tid);
          end
        end
      end
      MODE_SLEEP: begin
        if (!cur_valid) r.status = STAT_NO_THR;
        else if (cur_id == 0) r.status = STAT_MAIN_SLP;
        else begin
          sleeping[cur_id] = 1'b1;
          sum = {1'b0, global_quanta} + nq;
          deadline[cur_id] = sum[32] ? QuantaMax : sum[31:0];
          slot_state[cur_id] = RS_BLOCKED;
          switch_thread();
        end
      end
      MODE_QUERY: begin
        if (!present) r.status = STAT_NO_THR;
        else r.value = thread_quanta[tid];
      end
      default: ;
    endcase
    r.run_id = cur_valid ? cur_id : 4'd0;
    r.run_valid = cur_valid;
    r.total = global_quanta;
    return r;
  endfunction

  // Offer one command, hold it until transferred, then log its expected result.
  task automatic send_cmd(mode_e mode, logic [3:0] tid, logic [15:0] nq);
    bit go;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    thread_id_i <= tid;
    sleep_quanta_i <= nq;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      @(posedge clk_i);
    end while (!go);
    exp_store[exp_wr % EXP_DEPTH] = sched_command(mode, tid, nq);
    exp_wr++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare each transferred result against the oldest expectation.
  always @(negedge clk_i) begin
    sched_result_t exp_r;
    in_fire = in_valid_i && !in_stall_o;
    out_fire = out_valid_o && !out_stall_i;
    if (out_fire) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: result with nothing pending: status %0d value %0d", $time,
                 status_o, result_value_o);
        errors++;
      end else begin
        exp_r = exp_store[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          errors++;
        end
        if (result_value_o !== exp_r.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time, exp_r.value,
                   result_value_o);
          errors++;
        end
        if (running_thread_o !== exp_r.run_id) begin
          $display("%0t: running_thread expected %0d actual %0d", $time, exp_r.run_id,
                   running_thread_o);
          errors++;
        end
        if (running_valid_o !== exp_r.run_valid) begin
          $display("%0t: running_valid expected %0d actual %0d", $time, exp_r.run_valid,
                   running_valid_o);
          errors++;
        end
        if (total_quanta_o !== exp_r.total) begin
          $display("%0t: total_quanta expected %0d actual %0d", $time, exp_r.total,
                   total_quanta_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Boot state: main runs, cannot sleep; the no-op mode changes nothing.
  task automatic test_boot();
    send_cmd(MODE_QUERY, 4'd0, 16'd0);
    send_cmd(MODE_NOP, 4'd15, 16'hFFFF);
    send_cmd(MODE_SLEEP, 4'd0, 16'd5);
    send_cmd(MODE_RESUME, 4'd7, 16'd0);
  endtask

  // Fill every slot, then one spawn too many.
  task automatic test_spawn_fill();
    for (int i = 0; i < NTHR; i++) send_cmd(MODE_SPAWN, 4'd0, 16'd0);
    send_cmd(MODE_QUERY, 4'd15, 16'd0);
  endtask

  // Sleep extremes, block/resume of a sleeper, terminate running and free ids.
  task automatic test_thread_ops();
    send_cmd(MODE_TICK, 4'd0, 16'd0);
    send_cmd(MODE_SLEEP, 4'd0, 16'd0);       // wakes within the same switch
    send_cmd(MODE_SLEEP, 4'd0, 16'hFFFF);    // sleeps for good
    send_cmd(MODE_BLOCK, 4'd2, 16'd0);       // sleeper: flag only
    send_cmd(MODE_RESUME, 4'd2, 16'd0);      // still asleep, stays off the queue
    send_cmd(MODE_TERM, 4'd9, 16'd0);
    send_cmd(MODE_RESUME, 4'd9, 16'd0);      // freed id
    send_cmd(MODE_TERM, cur_id, 16'd0);      // running thread
  endtask

  function automatic logic [3:0] pick_thread();
    logic [3:0] t;
    if ($urandom_range(0, 99) < 25) return 4'($urandom_range(0, 15));
    for (int k = 0; k < 8; k++) begin
      t = 4'($urandom_range(0, 15));
      if (slot_used[t]) return t;
    end
    return t;
  endfunction

  // Random command mix weighted toward live threads and short sleeps.
  task automatic test_random(int count);
    int w;
    mode_e m;
    logic [15:0] nq;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= 200 && n < 300);
      if (n == 350) hold_req = 1'b1;
      w = $urandom_range(0, 99);
      if (w < 30) m = MODE_TICK;
      else if (w < 44) m = MODE_SPAWN;
      else if (w < 52) m = MODE_TERM;
      else if (w < 63) m = MODE_BLOCK;
      else if (w < 78) m = MODE_RESUME;
      else if (w < 90) m = MODE_SLEEP;
      else if (w < 98) m = MODE_QUERY;
      else m = MODE_NOP;
      nq = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      send_cmd(m, pick_thread(), nq);
    end
    quiet = 1'b0;
  endtask

  initial begin : main
    int waited;
    sched_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boot();
    test_spawn_fill();
    test_thread_ops();
    test_random(600);
    in_valid_i <= 1'b0;
    waited = 0;
    while (exp_wr != exp_rd && waited < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/rrts_pkg.sv
rtl/rrts_sat_inc.sv
rtl/round_robin_thread_scheduler.sv
test/round_robin_thread_scheduler_tb.sv
